>>> rtl/brs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types and constants for the bounded record stack: sizes, command
// and status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package brs_pkg;

	// storage sizes
	localparam int DEPTH      = 8;
	localparam int NAME_CHARS = 8;
	localparam int NAME_W     = 64;
	localparam int KIND_W     = 8;
	localparam int MIN_W      = 16;
	localparam int CAP_W      = 4;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(6);

	// keeps the first NAME_CHARS characters (high bytes) of a name
	localparam logic [NAME_W-1:0] NAME_MASK =
		~((NAME_W'(1) << (NAME_W - 8 * NAME_CHARS)) - NAME_W'(1));

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_PEEK  = 2'd3
	} cmd_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE  = 1'b0,
		S_DRAIN = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    push;
		logic    emit_top;
		logic    drop_top;
		logic    emit_err;
		status_t err_code;
		logic    emit_last;
	} brs_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic one_left;
		logic out_free;
	} brs_sts_t;

endpackage

>>> rtl/bounded_record_stack_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_record_stack_top
// Bounded LIFO stack of task records (name, kind, minutes).
//
// Command channel (cmd_valid/cmd_ready): command 0 push, 1 pop, 2 clear,
// 3 peek, with the record fields used by push. Result channel
// (res_valid/res_ready): status, record fields and a last flag on the
// final result of a command. Config channel (cfg_valid/cfg_ready/cfg_data)
// writes the capacity register; it is always ready.
// Push, pop and peek: a command is accepted whenever the output register
// is empty or being drained in the same cycle, and its result is valid in
// the next cycle. A successful push gives no result.
// Clear is decoded on transfer, then drains one record per cycle while the
// output register is free, top first: N stored records give N results,
// and no command is accepted until the final record is loaded
// into the output register. Clear on an empty stack gives no result.
// A stalled receiver holds the result register and stops new transfers.
// Reset empties the stack, sets capacity to 6 and drops result valid.
// ----------------------------------------------------------------------------
module bounded_record_stack_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [1:0]                   command,
	input  logic [brs_pkg::NAME_W-1:0]   task_name,
	input  logic [brs_pkg::KIND_W-1:0]   task_kind,
	input  logic [brs_pkg::MIN_W-1:0]    task_minutes,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [1:0]                   status,
	output logic [brs_pkg::NAME_W-1:0]   out_name,
	output logic [brs_pkg::KIND_W-1:0]   out_kind,
	output logic [brs_pkg::MIN_W-1:0]    out_minutes,
	output logic                         last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [brs_pkg::CAP_W-1:0]    cfg_data
);
	import brs_pkg::*;

	brs_ctl_t ctl;
	brs_sts_t sts;

	// command decode and drain sequencing
	brs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.command   (command),
		.sts       (sts),
		.ctl       (ctl)
	);

	// storage and result register
	brs_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.task_name    (task_name),
		.task_kind    (task_kind),
		.task_minutes (task_minutes),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.status       (status),
		.out_name     (out_name),
		.out_kind     (out_kind),
		.out_minutes  (out_minutes),
		.last         (last)
	);

endmodule

>>> rtl/brs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_ctrl
// Controller: decodes accepted commands and sequences the clear drain,
// one stored record per cycle while the output register is free.
// ----------------------------------------------------------------------------
module brs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [1:0]        command,
	input  brs_pkg::brs_sts_t sts,
	output brs_pkg::brs_ctl_t ctl
);
	import brs_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign cmd_ready = (state_q == S_IDLE) && sts.out_free;
	assign accept    = cmd_valid && cmd_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (command == CMD_CLEAR) && !sts.empty) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (sts.out_free && sts.one_left) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		ctl = '0;
		ctl.err_code = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						CMD_PUSH: begin
							if (sts.full) begin
								ctl.emit_err  = 1'b1;
								ctl.err_code  = ST_FULL;
								ctl.emit_last = 1'b1;
							end else begin
								ctl.push = 1'b1;
							end
						end
						CMD_POP, CMD_PEEK: begin
							ctl.emit_last = 1'b1;
							if (sts.empty) begin
								ctl.emit_err = 1'b1;
								ctl.err_code = ST_EMPTY;
							end else begin
								ctl.emit_top = 1'b1;
								ctl.drop_top = (command == CMD_POP);
							end
						end
						default: ;
					endcase
				end
			end
			S_DRAIN: begin
				if (sts.out_free) begin
					ctl.emit_top  = 1'b1;
					ctl.drop_top  = 1'b1;
					ctl.emit_last = sts.one_left;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/brs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_dpath
// Datapath: record store, fill count, capacity register and the result
// output register.
// ----------------------------------------------------------------------------
module brs_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  brs_pkg::brs_ctl_t            ctl,
	output brs_pkg::brs_sts_t            sts,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [brs_pkg::CAP_W-1:0]    cfg_data,
	input  logic [brs_pkg::NAME_W-1:0]   task_name,
	input  logic [brs_pkg::KIND_W-1:0]   task_kind,
	input  logic [brs_pkg::MIN_W-1:0]    task_minutes,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [1:0]                   status,
	output logic [brs_pkg::NAME_W-1:0]   out_name,
	output logic [brs_pkg::KIND_W-1:0]   out_kind,
	output logic [brs_pkg::MIN_W-1:0]    out_minutes,
	output logic                         last
);
	import brs_pkg::*;

	logic [NAME_W-1:0] names_q   [DEPTH];
	logic [KIND_W-1:0] kinds_q   [DEPTH];
	logic [MIN_W-1:0]  minutes_q [DEPTH];

	logic [CNT_W-1:0]  fill_q;
	logic [CAP_W-1:0]  cap_q;
	logic              res_valid_q;
	status_t           status_q;
	logic [NAME_W-1:0] name_q;
	logic [KIND_W-1:0] kind_q;
	logic [MIN_W-1:0]  minutes_q_out;
	logic              last_q;

	logic [CNT_W-1:0]  fill_m1;
	logic [IDX_W-1:0]  top_idx;
	logic [IDX_W-1:0]  push_idx;
	logic              emit;

	assign cfg_ready = 1'b1;
	assign fill_m1   = fill_q - CNT_W'(1);
	assign top_idx   = fill_m1[IDX_W-1:0];
	assign push_idx  = fill_q[IDX_W-1:0];
	assign emit      = ctl.emit_top || ctl.emit_err;

	// status toward the controller
	assign sts.empty    = (fill_q == '0);
	assign sts.one_left = (fill_q == CNT_W'(1));
	assign sts.full     = (CMP_W'(fill_q) >= CMP_W'(cap_q)) ||
	                      (CMP_W'(fill_q) >= CMP_W'(DEPTH));
	assign sts.out_free = !res_valid_q || res_ready;

	// control registers: count, capacity, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			cap_q       <= CAPACITY_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (ctl.push) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (ctl.drop_top) begin
				fill_q <= fill_m1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// record store write on push
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			names_q[push_idx]   <= task_name & NAME_MASK;
			kinds_q[push_idx]   <= task_kind;
			minutes_q[push_idx] <= task_minutes;
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (emit) begin
			last_q <= ctl.emit_last;
			if (ctl.emit_top) begin
				status_q      <= ST_OK;
				name_q        <= names_q[top_idx];
				kind_q        <= kinds_q[top_idx];
				minutes_q_out <= minutes_q[top_idx];
			end else begin
				status_q      <= ctl.err_code;
				name_q        <= '0;
				kind_q        <= '0;
				minutes_q_out <= '0;
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign out_name    = name_q;
	assign out_kind    = kind_q;
	assign out_minutes = minutes_q_out;
	assign last        = last_q;

endmodule

>>> test/tb_bounded_record_stack_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_record_stack_top
// Self-checking bench for the bounded record stack. A directed table covers
// the empty, full and clear cases, field extremes and capacity extremes.
// Random command phases follow under different sender and receiver idle
// mixes, with a capacity write before each phase. Every result transfer is
// compared field by field against a shadow stack kept in the bench.
// ----------------------------------------------------------------------------
module tb_bounded_record_stack_top;
	import brs_pkg::*;

	localparam int CLEAR_SETTLE = 4;      // cycles after the last result before idle
	localparam int END_SETTLE   = 8;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 9;

	typedef struct packed {
		status_t             status;
		logic [NAME_W-1:0]   name;
		logic [KIND_W-1:0]   kind;
		logic [MIN_W-1:0]    minutes;
		logic                last;
	} stack_rec_t;

	typedef struct {
		bit                  is_cap_write;
		logic [CAP_W-1:0]    cap;
		cmd_op_t             op;
		logic [NAME_W-1:0]   name;
		logic [KIND_W-1:0]   kind;
		logic [MIN_W-1:0]    minutes;
		bit                  typed;
		stack_rec_t          want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	logic [1:0]           command = '0;
	logic [NAME_W-1:0]    task_name = '0;
	logic [KIND_W-1:0]    task_kind = '0;
	logic [MIN_W-1:0]     task_minutes = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic [1:0]           status;
	logic [NAME_W-1:0]    out_name;
	logic [KIND_W-1:0]    out_kind;
	logic [MIN_W-1:0]     out_minutes;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CAP_W-1:0]     cfg_data = '0;

	// shadow copy of the stack and its capacity register
	logic [NAME_W-1:0]    shadow_name [DEPTH];
	logic [KIND_W-1:0]    shadow_kind [DEPTH];
	logic [MIN_W-1:0]     shadow_minutes [DEPTH];
	int                   shadow_fill = 0;
	int                   shadow_cap = int'(CAPACITY_RESET);

	stack_rec_t           expected_records [$];
	stim_row_t            stim_rows [$];

	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;
	int                   error_count = 0;
	int                   commands_sent = 0;
	int                   results_checked = 0;
	int                   cap_writes = 0;
	int                   cycle_count = 0;

	bounded_record_stack_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.command      (command),
		.task_name    (task_name),
		.task_kind    (task_kind),
		.task_minutes (task_minutes),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.status       (status),
		.out_name     (out_name),
		.out_kind     (out_kind),
		.out_minutes  (out_minutes),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_records.size());
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic stack_rec_t error_rec(status_t st);
		stack_rec_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic stack_rec_t top_rec(int idx, bit is_last);
		stack_rec_t r;
		r.status = ST_OK;
		r.name = shadow_name[idx];
		r.kind = shadow_kind[idx];
		r.minutes = shadow_minutes[idx];
		r.last = is_last;
		return r;
	endfunction

	// append one record to the expected queue
	function automatic void expect_record(stack_rec_t r);
		expected_records = {expected_records, r};
	endfunction

	// apply one command to the shadow stack and queue the records it yields
	function automatic void predict_stack_op(cmd_op_t op, logic [NAME_W-1:0] nm,
			logic [KIND_W-1:0] kd, logic [MIN_W-1:0] mn);
		int eff_cap;
		eff_cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
		case (op)
			CMD_PUSH: begin
				if (shadow_fill >= eff_cap) begin
					expect_record(error_rec(ST_FULL));
				end else begin
					shadow_name[shadow_fill] = nm & NAME_MASK;
					shadow_kind[shadow_fill] = kd;
					shadow_minutes[shadow_fill] = mn;
					shadow_fill++;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (shadow_fill == 0) begin
					expect_record(error_rec(ST_EMPTY));
				end else begin
					expect_record(top_rec(shadow_fill - 1, 1'b1));
					if (op == CMD_POP)
						shadow_fill--;
				end
			end
			default: begin
				while (shadow_fill > 0) begin
					expect_record(top_rec(shadow_fill - 1, shadow_fill == 1));
					shadow_fill--;
				end
			end
		endcase
	endfunction

	function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			error_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		stack_rec_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_records.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d name %h",
					$time, status, out_name);
				error_count++;
			end else begin
				want = expected_records.pop_front();
				results_checked++;
				check_field("status", 64'(want.status), 64'(status));
				check_field("out_name", want.name, out_name);
				check_field("out_kind", 64'(want.kind), 64'(out_kind));
				check_field("out_minutes", 64'(want.minutes), 64'(out_minutes));
				check_field("last", 64'(want.last), 64'(last));
			end
		end
	end

	// one command transfer; valid stays high for the caller's next item
	task automatic send_item(input cmd_op_t op, input logic [NAME_W-1:0] nm,
			input logic [KIND_W-1:0] kd, input logic [MIN_W-1:0] mn,
			input bit typed, input stack_rec_t want);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= op;
		task_name <= nm;
		task_kind <= kd;
		task_minutes <= mn;
		do @(posedge clk); while (!cmd_ready);
		predict_stack_op(op, nm, kd, mn);
		// a hand-written expectation replaces the predicted one
		if (typed) begin
			expected_records.delete(expected_records.size() - 1);
			expect_record(want);
		end
		commands_sent++;
	endtask

	task automatic wait_drained();
		while (expected_records.size() != 0)
			@(posedge clk);
	endtask

	// capacity write once the block has gone quiet
	task automatic write_capacity(input logic [CAP_W-1:0] v);
		cmd_valid <= 1'b0;
		wait_drained();
		repeat (CLEAR_SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_cap = int'(v);
		cap_writes++;
	endtask

	task automatic send_random_item();
		cmd_op_t op;
		logic [NAME_W-1:0] nm;
		logic [KIND_W-1:0] kd;
		logic [MIN_W-1:0] mn;
		int pick;
		int len;
		pick = int'($urandom_range(99));
		if (pick < 50)
			op = CMD_PUSH;
		else if (pick < 70)
			op = CMD_POP;
		else if (pick < 85)
			op = CMD_PEEK;
		else
			op = CMD_CLEAR;
		nm = {$urandom, $urandom};
		// readable names for half the items, zero padded
		if ($urandom_range(1) == 0) begin
			len = int'($urandom_range(8));
			for (int i = 0; i < 8; i++)
				nm[63 - 8 * i -: 8] = (i < len) ? 8'($urandom_range(65, 90)) : 8'h00;
		end
		kd = KIND_W'($urandom_range(255));
		pick = int'($urandom_range(9));
		mn = (pick == 0) ? '0 : (pick == 1) ? '1 : MIN_W'($urandom_range(65535));
		send_item(op, nm, kd, mn, 1'b0, '0);
	endtask

	function automatic void add_cmd(cmd_op_t op, logic [NAME_W-1:0] nm,
			logic [KIND_W-1:0] kd, logic [MIN_W-1:0] mn);
		stim_row_t row;
		row.is_cap_write = 1'b0;
		row.cap = '0;
		row.op = op;
		row.name = nm;
		row.kind = kd;
		row.minutes = mn;
		row.typed = 1'b0;
		row.want = '0;
		stim_rows = {stim_rows, row};
	endfunction

	function automatic void add_checked(cmd_op_t op, logic [NAME_W-1:0] nm,
			stack_rec_t want);
		add_cmd(op, nm, '0, '0);
		stim_rows[stim_rows.size() - 1].typed = 1'b1;
		stim_rows[stim_rows.size() - 1].want = want;
	endfunction

	function automatic void add_cap(logic [CAP_W-1:0] v);
		stim_row_t row;
		row.is_cap_write = 1'b1;
		row.cap = v;
		row.op = CMD_PUSH;
		row.name = '0;
		row.kind = '0;
		row.minutes = '0;
		row.typed = 1'b0;
		row.want = '0;
		stim_rows = {stim_rows, row};
	endfunction

	initial begin
		stim_row_t row;
		int phase_caps [PHASES];
		int directed_count;

		phase_caps = '{1, 8, 15, 0, 3, 0, 5, 7};
		phase_caps[5] = int'($urandom_range(15));

		// directed table: empty, extremes, full, clear, capacity extremes
		add_checked(CMD_POP, '0, error_rec(ST_EMPTY));
		add_checked(CMD_PEEK, '1, error_rec(ST_EMPTY));
		add_cmd(CMD_CLEAR, '0, '0, '0);
		add_cmd(CMD_PUSH, '1, 8'hFF, 16'hFFFF);
		add_checked(CMD_PEEK, '0, '{ST_OK, {NAME_W{1'b1}}, 8'hFF, 16'hFFFF, 1'b1});
		add_cmd(CMD_PUSH, '0, '0, '0);
		add_checked(CMD_POP, '0, '{ST_OK, {NAME_W{1'b0}}, 8'h00, 16'h0000, 1'b1});
		add_cmd(CMD_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 16'hAAAA);
		add_cmd(CMD_PUSH, 64'h5555_5555_5555_5555, 8'hAA, 16'h5555);
		add_cmd(CMD_PUSH, 64'h4255_494C_4400_0000, 8'h62, 16'd1234);
		add_cmd(CMD_PUSH, 64'h4445_504C_4F59_0000, 8'h64, 16'd90);
		add_cmd(CMD_PUSH, 64'h5245_504F_5254_5321, 8'h78, 16'd480);
		add_checked(CMD_PUSH, '1, error_rec(ST_FULL));
		add_cmd(CMD_PEEK, '0, '0, '0);
		add_cmd(CMD_CLEAR, '0, '0, '0);
		// capacity zero: always full
		add_cap(4'd0);
		add_checked(CMD_PUSH, '0, error_rec(ST_FULL));
		// capacity above depth saturates
		add_cap(4'd15);
		for (int i = 0; i < DEPTH; i++)
			add_cmd(CMD_PUSH, {$urandom, $urandom}, 8'($urandom), 16'($urandom));
		add_checked(CMD_PUSH, '0, error_rec(ST_FULL));
		// capacity dropped below the fill count
		add_cap(4'd2);
		add_checked(CMD_PUSH, '0, error_rec(ST_FULL));
		add_cmd(CMD_POP, '0, '0, '0);
		add_cmd(CMD_CLEAR, '1, '1, '1);

		// reset
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.is_cap_write)
				write_capacity(row.cap);
			else
				send_item(row.op, row.name, row.kind, row.minutes, row.typed, row.want);
		end
		directed_count = commands_sent;

		// random phases, one capacity and one idle mix each
		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(CAP_W'(phase_caps[ph]));
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 64;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 64;
				end
				default: begin
					send_idle_pct = 37;
					recv_stall_pct = 37;
				end
			endcase
			repeat (PHASE_ITEMS) send_random_item();
		end

		// drain and settle
		cmd_valid <= 1'b0;
		wait_drained();
		repeat (END_SETTLE) @(posedge clk);

		$display("summary: %0d commands (%0d directed), %0d results checked",
			commands_sent, directed_count, results_checked);
		$display("summary: %0d capacity writes, idle mixes none/sender/receiver/both, %0d errors",
			cap_writes, error_count);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
